FILE: hw/rtl/gba3_pkg.sv
// shared types and constants for the 3d grid binning block
package gba3_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned IDXO_W  = 12;
  localparam int unsigned AXIS_QW = 8;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned NUM_W   = DIFF_W + AXIS_QW;
  localparam int unsigned QDIV_W  = SUM_W + 1;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] REG_X_LOW  = 3'd0;
  localparam logic [2:0] REG_X_HIGH = 3'd1;
  localparam logic [2:0] REG_Y_LOW  = 3'd2;
  localparam logic [2:0] REG_Y_HIGH = 3'd3;
  localparam logic [2:0] REG_Z_LOW  = 3'd4;
  localparam logic [2:0] REG_Z_HIGH = 3'd5;
  localparam logic [2:0] REG_NORM   = 3'd6;

  localparam logic [SUM_W-1:0] SUM_POS_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_NEG_MAX = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [11:0] {
    S_CLEAR = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_MUL   = 12'b0000_0000_0100,
    S_DIV   = 12'b0000_0000_1000,
    S_ROUND = 12'b0000_0001_0000,
    S_LIN   = 12'b0000_0010_0000,
    S_WB    = 12'b0000_0100_0000,
    S_READ  = 12'b0000_1000_0000,
    S_RCHK  = 12'b0001_0000_0000,
    S_QDIV  = 12'b0010_0000_0000,
    S_QFIN  = 12'b0100_0000_0000,
    S_EMIT  = 12'b1000_0000_0000
  } state_t;

endpackage

FILE: hw/rtl/grid_binning_average_3d_core.sv
// 3d nearest-cell binning with per-cell sum and hit count, read-out averaged or raw
//
// channel  dir  signals                       content
// s        in   s_tvalid s_tready s_tdata     sample, read or clear request
//                         s_tuser             operation code
// m        out  m_tvalid m_tready m_tdata     one result per request
// cfg      in   cfg_we cfg_index cfg_data     box bounds and normalize flag
//
// add: multiply, 8-step index division per axis, rounding and cell
// read-modify-write; a skipped or outside sample goes straight to its
// result. read: raw, or averaged by the 49-step quotient unit; clear: a sweep
// of all CELLS_X*CELLS_Y*CELLS_Z cells; unknown: straight to its result.
// after reset a clearing pass over all CELLS_X*CELLS_Y*CELLS_Z cells runs
// before the first request is taken. a result waits in the output register
// while the next request is taken; a request only stalls at its end if that
// register is still occupied.
module grid_binning_average_3d_core #(
  parameter int unsigned CELLS_X = 16,
  parameter int unsigned CELLS_Y = 16,
  parameter int unsigned CELLS_Z = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // x_coord[31:0] y_coord[63:32] z_coord[95:64] sample_value[127:96]
  // sample_valid[128] read_index[140:129], zero pad to 144
  input  logic [143:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // cell_value[47:0] cell_hits[79:48] hit_cell[91:80] in_bounds[92]
  // outside_total[124:93], zero pad to 128
  output logic [127:0] m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import gba3_pkg::*;

  localparam int unsigned TOTAL = CELLS_X * CELLS_Y * CELLS_Z;
  localparam int unsigned AW    = $clog2(TOTAL);
  localparam int unsigned MW    = SUM_W + CNT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL - 1);
  localparam logic [AXIS_QW-1:0] CM1_X = AXIS_QW'(CELLS_X - 1);
  localparam logic [AXIS_QW-1:0] CM1_Y = AXIS_QW'(CELLS_Y - 1);
  localparam logic [AXIS_QW-1:0] CM1_Z = AXIS_QW'(CELLS_Z - 1);

  // configuration
  logic signed [COORD_W-1:0] bnd_low  [3];
  logic signed [COORD_W-1:0] bnd_high [3];
  logic                      norm_en;

  state_t state;
  logic   clr_emit;
  logic [AW-1:0] clr_addr;

  // request fields
  logic signed [COORD_W-1:0] pos [3];
  logic signed [COORD_W-1:0] in_value;
  logic                      in_valid;
  logic [IDXO_W-1:0]         in_index;
  logic                      pt_inside;

  logic signed [COORD_W-1:0] smp_value;
  logic [AW-1:0]             rd_idx;

  // axis index units
  logic [AXIS_QW-1:0] cm1 [3];
  logic [DIFF_W-1:0]  diff [3];
  logic [DIFF_W-1:0]  den  [3];
  logic [NUM_W-1:0]   arem [3];
  logic [NUM_W-1:0]   adsh [3];
  logic [AXIS_QW-1:0] aq   [3];
  logic [AXIS_QW-1:0] aidx [3];
  logic [AXIS_QW:0]   qn   [3];
  logic [NUM_W:0]     r2   [3];
  logic [NUM_W:0]     dd   [3];
  logic [2:0]         acnt;
  logic [AW-1:0]      lin;
  logic [AW-1:0]      lin_c;

  // memory
  logic [MW-1:0] mem [TOTAL];
  logic [MW-1:0] rd_data;
  logic [MW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic signed [SUM_W-1:0] rd_sum;
  logic [CNT_W-1:0]        rd_cnt;
  logic signed [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0]        sum_new;
  logic [CNT_W-1:0]        cnt_new;

  // read quotient unit
  logic [QDIV_W-1:0] qd;
  logic [CNT_W:0]    qe;
  logic [CNT_W:0]    qrem;
  logic [CNT_W+1:0]  qrsh;
  logic [5:0]        qcnt;
  logic              qneg;
  logic [SUM_W-1:0]  mag;

  // result
  logic [SUM_W-1:0]  res_value;
  logic [CNT_W-1:0]  res_hits;
  logic [IDXO_W-1:0] res_cell;
  logic              res_inb;
  logic [CNT_W-1:0]  outside_cnt;

  logic out_free;
  logic s_xfer;

  assign pos[0]    = s_tdata[31:0];
  assign pos[1]    = s_tdata[63:32];
  assign pos[2]    = s_tdata[95:64];
  assign in_value  = s_tdata[127:96];
  assign in_valid  = s_tdata[128];
  assign in_index  = s_tdata[140:129];

  assign cm1[0] = CM1_X;
  assign cm1[1] = CM1_Y;
  assign cm1[2] = CM1_Z;

  assign s_tready = (state == S_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign pt_inside = (pos[0] >= bnd_low[0]) && (pos[0] <= bnd_high[0]) &&
                     (pos[1] >= bnd_low[1]) && (pos[1] <= bnd_high[1]) &&
                     (pos[2] >= bnd_low[2]) && (pos[2] <= bnd_high[2]);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      r2[a] = {arem[a], 1'b0};
      dd[a] = (NUM_W+1)'(den[a]);
      qn[a] = {1'b0, aq[a]};
      if ((r2[a] > dd[a]) || ((r2[a] == dd[a]) && aq[a][0])) begin
        qn[a] = qn[a] + 1'b1;
      end
      if (den[a] == '0) begin
        qn[a] = '0;
      end
      if (qn[a] > {1'b0, cm1[a]}) begin
        qn[a] = {1'b0, cm1[a]};
      end
    end
  end

  assign lin_c = AW'(32'(aidx[0]) * 32'(CELLS_Y * CELLS_Z) +
                     32'(aidx[1]) * 32'(CELLS_Z) + 32'(aidx[2]));

  assign rd_sum  = rd_data[SUM_W-1:0];
  assign rd_cnt  = rd_data[MW-1:SUM_W];
  assign sum_ext = {rd_sum[SUM_W-1], rd_sum} + (SUM_W+1)'(smp_value);

  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_new = sum_ext[SUM_W] ? SUM_NEG_MAX : SUM_POS_MAX;
    end else begin
      sum_new = sum_ext[SUM_W-1:0];
    end
    cnt_new = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
    mag     = rd_sum[SUM_W-1] ? SUM_W'(-rd_sum) : rd_sum;
    qrsh    = {qrem, qd[QDIV_W-1]};
  end

  always_comb begin
    rd_addr = rd_idx;
    wr_en   = 1'b0;
    wr_addr = lin;
    wr_data = {cnt_new, sum_new};
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      S_LIN:   rd_addr = lin_c;
      S_WB:    wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bnd_low[0]  <= '0;
      bnd_low[1]  <= '0;
      bnd_low[2]  <= '0;
      bnd_high[0] <= 32'sd65536;
      bnd_high[1] <= 32'sd65536;
      bnd_high[2] <= 32'sd65536;
      norm_en     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_LOW:  bnd_low[0]  <= cfg_data;
        REG_X_HIGH: bnd_high[0] <= cfg_data;
        REG_Y_LOW:  bnd_low[1]  <= cfg_data;
        REG_Y_HIGH: bnd_high[1] <= cfg_data;
        REG_Z_LOW:  bnd_low[2]  <= cfg_data;
        REG_Z_HIGH: bnd_high[2] <= cfg_data;
        REG_NORM:   norm_en     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_emit    <= 1'b0;
      clr_addr    <= '0;
      outside_cnt <= '0;
      m_tvalid    <= 1'b0;
      acnt        <= '0;
      qcnt        <= '0;
    end else begin
      if ((state == S_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == LAST_ADDR) begin
            clr_addr <= '0;
            state    <= clr_emit ? S_EMIT : S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (s_xfer) begin
            unique case (s_tuser)
              OP_ADD: begin
                if (in_valid && pt_inside) begin
                  state <= S_MUL;
                end else begin
                  if (in_valid && outside_cnt != '1) begin
                    outside_cnt <= outside_cnt + 1'b1;
                  end
                  state <= S_EMIT;
                end
              end
              OP_READ:  state <= (32'(in_index) < 32'(TOTAL)) ? S_READ : S_EMIT;
              OP_CLEAR: begin
                clr_emit <= 1'b1;
                state    <= S_CLEAR;
              end
              default:  state <= S_EMIT;
            endcase
          end
        end
        S_MUL: begin
          acnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          acnt <= acnt + 1'b1;
          if (acnt == 3'(AXIS_QW - 1)) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: state <= S_LIN;
        S_LIN:   state <= S_WB;
        S_WB:    state <= S_EMIT;
        S_READ:  state <= S_RCHK;
        S_RCHK: begin
          qcnt  <= '0;
          state <= (norm_en && rd_cnt != '0) ? S_QDIV : S_EMIT;
        end
        S_QDIV: begin
          qcnt <= qcnt + 1'b1;
          if (qcnt == 6'(QDIV_W - 1)) begin
            state <= S_QFIN;
          end
        end
        S_QFIN:  state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            clr_emit <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        for (int a = 0; a < 3; a++) begin
          diff[a] <= DIFF_W'(pos[a]) - DIFF_W'(bnd_low[a]);
          den[a]  <= DIFF_W'(bnd_high[a]) - DIFF_W'(bnd_low[a]);
        end
        smp_value <= in_value;
        rd_idx    <= AW'(in_index);
        res_value <= '0;
        res_hits  <= '0;
        res_cell  <= '0;
        res_inb   <= 1'b0;
      end
      S_MUL: begin
        for (int a = 0; a < 3; a++) begin
          arem[a] <= NUM_W'(diff[a]) * NUM_W'(cm1[a]);
          adsh[a] <= NUM_W'({den[a], {(AXIS_QW-1){1'b0}}});
          aq[a]   <= '0;
        end
      end
      S_DIV: begin
        for (int a = 0; a < 3; a++) begin
          if (arem[a] >= adsh[a]) begin
            arem[a] <= arem[a] - adsh[a];
            aq[a]   <= {aq[a][AXIS_QW-2:0], 1'b1};
          end else begin
            aq[a]   <= {aq[a][AXIS_QW-2:0], 1'b0};
          end
          adsh[a] <= adsh[a] >> 1;
        end
      end
      S_ROUND: begin
        for (int a = 0; a < 3; a++) begin
          aidx[a] <= qn[a][AXIS_QW-1:0];
        end
      end
      S_LIN: lin <= lin_c;
      S_WB: begin
        res_cell <= IDXO_W'(lin);
        res_inb  <= 1'b1;
      end
      S_RCHK: begin
        res_hits  <= rd_cnt;
        res_value <= rd_sum;
        qneg      <= rd_sum[SUM_W-1];
        qd        <= {mag, 1'b0} + QDIV_W'(rd_cnt);
        qe        <= {rd_cnt, 1'b0};
        qrem      <= '0;
      end
      S_QDIV: begin
        if (qrsh >= (CNT_W+2)'(qe)) begin
          qrem <= (CNT_W+1)'(qrsh - (CNT_W+2)'(qe));
          qd   <= {qd[QDIV_W-2:0], 1'b1};
        end else begin
          qrem <= qrsh[CNT_W:0];
          qd   <= {qd[QDIV_W-2:0], 1'b0};
        end
      end
      S_QFIN: res_value <= qneg ? SUM_W'(-qd[SUM_W-1:0]) : qd[SUM_W-1:0];
      S_EMIT: begin
        if (out_free) begin
          m_tdata <= {3'b0, outside_cnt, res_inb, res_cell, res_hits, res_value};
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the 3d grid binning core with its own cell model
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gba3_pkg::*;

  localparam int NX = 16, NY = 16, NZ = 16;
  localparam int NCELLS = NX * NY * NZ;
  localparam int WATCH_LIMIT = 200000;
  localparam longint SUM_HI = 64'sd140737488355327;
  localparam longint SUM_LO = -64'sd140737488355328;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] px, py, pz, val;
    logic        ok;
    logic [11:0] ridx;
  } request_t;

  // first member sits in the top bits
  typedef struct packed {
    logic [31:0] outside;
    logic        inb;
    logic [11:0] hcell;
    logic [31:0] hits;
    logic [47:0] value;
  } answer_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
  logic [143:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic [127:0] m_tdata;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  grid_binning_average_3d_core dut (.*);

  initial forever #2 clk = ~clk;

  // model state
  longint      sums [NCELLS];
  logic [31:0] counts [NCELLS];
  logic [31:0] outside_cnt;
  longint      lo [3], hi [3];
  logic        norm;

  request_t pending [$];
  answer_t  awaited [$];
  int errors = 0;
  int watch = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic longint axis_cell(longint p, longint l, longint h, int n);
    longint num, den, q, r;
    den = h - l;
    if (den == 0) return 0;
    num = (p - l) * (n - 1);
    q = num / den;
    r = num % den;
    if (2 * r > den || (2 * r == den && q[0])) q++;
    if (q > n - 1) q = n - 1;
    return q;
  endfunction

  function automatic answer_t bin_predict(request_t rq);
    answer_t a;
    longint p [3];
    longint lin, s, m, q, c;
    bit in_box;
    a = '0;
    if (rq.op == OP_ADD) begin
      p[0] = longint'(signed'(rq.px));
      p[1] = longint'(signed'(rq.py));
      p[2] = longint'(signed'(rq.pz));
      if (rq.ok) begin
        in_box = 1;
        for (int k = 0; k < 3; k++) if (p[k] < lo[k] || p[k] > hi[k]) in_box = 0;
        if (in_box) begin
          lin = axis_cell(p[0], lo[0], hi[0], NX) * NY * NZ
              + axis_cell(p[1], lo[1], hi[1], NY) * NZ + axis_cell(p[2], lo[2], hi[2], NZ);
          if (lin >= NCELLS) lin = NCELLS - 1;
          s = sums[lin] + longint'(signed'(rq.val));
          if (s > SUM_HI) s = SUM_HI;
          if (s < SUM_LO) s = SUM_LO;
          sums[lin] = s;
          if (counts[lin] != 32'hFFFF_FFFF) counts[lin]++;
          a.hcell = lin[11:0];
          a.inb = 1;
        end else if (outside_cnt != 32'hFFFF_FFFF) begin
          outside_cnt++;
        end
      end
    end else if (rq.op == OP_READ) begin
      if (rq.ridx < NCELLS) begin
        s = sums[rq.ridx];
        c = counts[rq.ridx];
        a.hits = counts[rq.ridx];
        if (norm && c != 0) begin
          m = (s < 0) ? -s : s;
          q = (2 * m + c) / (2 * c);
          if (s < 0) q = -q;
          a.value = q[47:0];
        end else begin
          a.value = s[47:0];
        end
      end
    end else begin
      // clear and the unknown code both report the same way; only clear wipes
      if (rq.op == OP_CLEAR)
        for (int i = 0; i < NCELLS; i++) begin
          sums[i] = 0;
          counts[i] = 0;
        end
    end
    a.outside = outside_cnt;
    return a;
  endfunction

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        awaited.push_back(bin_predict(pending.pop_front()));
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap > 0) begin
          gap--;
          s_tvalid <= 0;
        end else if (pending.size() > 0) begin
          request_t nx;
          nx = pending[0];
          s_tvalid <= 1;
          s_tuser <= nx.op;
          s_tdata <= {3'b0, nx.ridx, nx.ok, nx.val, nx.pz, nx.py, nx.px};
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  int stall = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        answer_t got, exp;
        got = m_tdata[124:0];
        if (awaited.size() == 0) report("result with nothing expected");
        else begin
          exp = awaited.pop_front();
          if (got.value !== exp.value)
            report($sformatf("cell_value %h exp %h", got.value, exp.value));
          if (got.hits !== exp.hits)
            report($sformatf("cell_hits %h exp %h", got.hits, exp.hits));
          if (got.hcell !== exp.hcell)
            report($sformatf("hit_cell %h exp %h", got.hcell, exp.hcell));
          if (got.inb !== exp.inb)
            report($sformatf("in_bounds %b exp %b", got.inb, exp.inb));
          if (got.outside !== exp.outside)
            report($sformatf("outside_total %h exp %h", got.outside, exp.outside));
        end
        stall = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) stall = 0;
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) watch <= 0;
    else begin
      watch <= watch + 1;
      if (watch >= WATCH_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_X_LOW:  lo[0] = longint'(signed'(v));
      REG_X_HIGH: hi[0] = longint'(signed'(v));
      REG_Y_LOW:  lo[1] = longint'(signed'(v));
      REG_Y_HIGH: hi[1] = longint'(signed'(v));
      REG_Z_LOW:  lo[2] = longint'(signed'(v));
      REG_Z_HIGH: hi[2] = longint'(signed'(v));
      REG_NORM:   norm = v[0];
      default: ;
    endcase
  endtask

  task automatic set_box(input logic [31:0] l, input logic [31:0] h, input logic n);
    write_reg(REG_X_LOW, l);  write_reg(REG_X_HIGH, h);
    write_reg(REG_Y_LOW, l);  write_reg(REG_Y_HIGH, h);
    write_reg(REG_Z_LOW, l);  write_reg(REG_Z_HIGH, h);
    write_reg(REG_NORM, {31'b0, n});
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (pending.size() != 0 || awaited.size() != 0) @(posedge clk);
    // a clear ends its sweep before its result; this wait is extra margin
    repeat (NCELLS + 100) @(posedge clk);
  endtask

  function automatic request_t mk(input logic [1:0] op);
    request_t r;
    r.op = op;
    r.px = $urandom; r.py = $urandom; r.pz = $urandom; r.val = $urandom;
    r.ok = 1'b1; r.ridx = 12'($urandom);
    return r;
  endfunction

  // coordinate mostly inside the current box of axis k
  function automatic logic [31:0] coord_in(int k);
    longint w, p;
    if (hi[k] < lo[k] || $urandom_range(0, 9) == 0) return $urandom;
    w = hi[k] - lo[k];
    case ($urandom_range(0, 3))
      0: p = lo[k];
      1: p = hi[k];
      default: p = lo[k] + (longint'({$urandom, $urandom}) & 64'h7FFF_FFFF_FFFF_FFFF) % (w + 1);
    endcase
    return p[31:0];
  endfunction

  task automatic random_phase(int n);
    request_t r;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: r = mk(OP_CLEAR);
        1: r = mk(OP_UNUSED);
        2, 3, 4, 5, 6: r = mk(OP_READ);
        default: begin
          r = mk(OP_ADD);
          r.px = coord_in(0); r.py = coord_in(1); r.pz = coord_in(2);
          r.ok = ($urandom_range(0, 9) != 0);
          if ($urandom_range(0, 7) == 0) r.val = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        end
      endcase
      pending.push_back(r);
    end
  endtask

  initial begin
    request_t r;
    for (int i = 0; i < NCELLS; i++) begin
      sums[i] = 0;
      counts[i] = 0;
    end
    outside_cnt = 0;
    for (int k = 0; k < 3; k++) begin
      lo[k] = 0;
      hi[k] = 65536;
    end
    norm = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: corners, halfway ties, invalid, outside, reads, clear, unknown
    r = mk(OP_ADD); r.px = 0; r.py = 0; r.pz = 0; r.val = 32'h7FFF_FFFF; pending.push_back(r);
    r.px = 65536; r.py = 65536; r.pz = 65536; r.val = 32'h8000_0000; pending.push_back(r);
    r.px = 32768; r.py = 2185; r.pz = 6554; r.val = 3; pending.push_back(r);
    r.ok = 1'b0; pending.push_back(r);
    r.ok = 1'b1; r.px = 32'hFFFF_FFFF; pending.push_back(r);
    r.px = 65537; pending.push_back(r);
    r = mk(OP_READ); r.ridx = 12'd0; pending.push_back(r);
    r.ridx = 12'd4095; pending.push_back(r);
    r.ridx = 12'hFFF; pending.push_back(r);
    pending.push_back(mk(OP_UNUSED));
    pending.push_back(mk(OP_CLEAR));
    r = mk(OP_READ); r.ridx = 12'd0; pending.push_back(r);
    drain();

    // degenerate box: only the low corner lands, maximum values pile up in cell 0
    set_box(32'h0000_1000, 32'h0000_1000, 0);
    r = mk(OP_ADD); r.px = 32'h1000; r.py = 32'h1000; r.pz = 32'h1000;
    repeat (4) begin
      r.val = 32'h7FFF_FFFF;
      pending.push_back(r);
    end
    r = mk(OP_READ); r.ridx = 12'd0; pending.push_back(r);
    random_phase(150);
    drain();

    // full signed range per axis
    set_box(32'h8000_0000, 32'h7FFF_FFFF, 1);
    random_phase(400);
    drain();

    // inverted box: every valid sample is outside
    set_box(32'h0001_0000, 32'hFFFF_0000, 1);
    random_phase(200);
    drain();

    set_box(32'hFFF0_0000, 32'h0010_0000, 0);
    random_phase(400);
    drain();

    set_box(32'h0000_0000, 32'h0001_0000, 1);
    random_phase(400);
    drain();

    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule
